### rtl/kca_pkg.sv
// shared types and constants of the k-means centroid accumulator
package kca_pkg;

    // command codes
    localparam logic [1:0] CMD_ACC   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic REG_DIM      = 1'b0;
    localparam logic REG_CLUSTERS = 1'b1;

    // widths and limits
    localparam int SUM_W   = 56;
    localparam int COUNT_W = 24;
    localparam int QDEPTH  = 2;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 24'hFFFFFF;
    localparam logic signed [SUM_W-1:0] SUM_MAX = 56'sh7FFFFFFFFFFFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 56'sh80000000000000;

    // input word
    typedef struct packed {
        logic [1:0]         cmd;
        logic [3:0]         cluster_id;
        logic [6:0]         coord_index;
        logic signed [31:0] sample_value;
        logic               vector_end;
    } kca_in_t;

    // result word
    typedef struct packed {
        logic signed [31:0] mean_value;
        logic               cluster_empty;
        logic [23:0]        vector_count;
        logic               count_overflow;
    } kca_out_t;

    // front to back queue handshake
    typedef struct packed {
        logic    valid;
        kca_in_t item;
    } kca_q_t;

    // back end sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC,
        ST_DLOAD,
        ST_DIV,
        ST_OUT
    } kca_state_t;

endpackage

### rtl/kca_ram.sv
// generic single write, single read port ram with registered read
module kca_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 2048
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end
endmodule

### rtl/kca_front.sv
// front end: config registers, range check and a two word queue
module kca_front #(
    parameter int MAX_CLUSTERS = 16,
    parameter int MAX_DIM      = 128
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  kca_pkg::kca_in_t s_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic            cfg_index,
    input  logic [7:0]      cfg_data,
    output kca_pkg::kca_q_t q_out,
    input  logic            q_pop
);
    import kca_pkg::*;

    logic [7:0] dim_reg, dim_next;
    logic [4:0] ncl_reg, ncl_next;
    kca_in_t    q_mem_reg [QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       accept, in_range, keep, push;

    assign cfg_ready = 1'b1;
    assign s_ready   = (cnt_reg != 2'(QDEPTH));
    assign accept    = s_valid && s_ready;

    // range check against live config and the storage size
    always_comb begin
        in_range = ({28'd0, s_data.cluster_id} < {27'd0, ncl_reg})
                && ({28'd0, s_data.cluster_id} < 32'(MAX_CLUSTERS))
                && ({25'd0, s_data.coord_index} < {24'd0, dim_reg})
                && ({25'd0, s_data.coord_index} < 32'(MAX_DIM));
        keep = (s_data.cmd == CMD_CLEAR)
            || (((s_data.cmd == CMD_ACC) || (s_data.cmd == CMD_READ)) && in_range);
        push = accept && keep;
    end

    // config writes
    always_comb begin
        dim_next = dim_reg;
        ncl_next = ncl_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_DIM:      dim_next = cfg_data;
                REG_CLUSTERS: ncl_next = cfg_data[4:0];
                default:      dim_next = dim_reg;
            endcase
        end
    end

    // queue pointers
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = 2'(cnt_reg + {1'b0, push} - {1'b0, q_pop});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_reg    <= 8'd128;
            ncl_reg    <= 5'd16;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            dim_reg    <= dim_next;
            ncl_reg    <= ncl_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= s_data;
        end
    end

    assign q_out.valid = (cnt_reg != 2'd0);
    assign q_out.item  = q_mem_reg[rd_ptr_reg];

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'(QDEPTH)) else $error("queue count out of bounds");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> cnt_reg != 2'd0) else $error("pop from empty queue");
    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !q_pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count missed a push");
`endif
endmodule

### rtl/kca_back.sv
// back end: sum store, counts, serial divider and result register
module kca_back #(
    parameter int MAX_CLUSTERS = 16,
    parameter int MAX_DIM      = 128
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  kca_pkg::kca_q_t  q_in,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output kca_pkg::kca_out_t m_data
);
    import kca_pkg::*;

    localparam int DEPTH = MAX_CLUSTERS * MAX_DIM;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int CIDW  = MAX_CLUSTERS > 1 ? $clog2(MAX_CLUSTERS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    kca_state_t state_reg, state_next;

    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    kca_in_t            item_reg, item_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0]   quo_reg, quo_next;
    logic               neg_reg, neg_next;
    logic [5:0]         bit_reg, bit_next;
    logic               ovf_reg, ovf_next;
    logic [COUNT_W-1:0] counts_reg [MAX_CLUSTERS];
    logic [COUNT_W-1:0] counts_next [MAX_CLUSTERS];
    logic               out_valid_reg, out_valid_next;
    kca_out_t           out_data_reg, out_data_next;

    logic               ram_wr_en, ram_rd_en;
    logic [AW-1:0]      ram_wr_addr, ram_rd_addr;
    logic signed [SUM_W-1:0] ram_wr_data, ram_rd_data;

    logic [CIDW-1:0]    q_cid, item_cid;
    logic [AW-1:0]      q_slot, item_slot;
    logic signed [SUM_W:0] sum_wide;
    logic [COUNT_W:0]   trial, shifted;
    logic [31:0]        mean_sat;
    logic               out_free, out_load;

    kca_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH)) u_sums (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // slot addresses
    assign q_cid     = CIDW'(q_in.item.cluster_id);
    assign item_cid  = CIDW'(item_reg.cluster_id);
    assign q_slot    = AW'(AW'(q_in.item.cluster_id) * AW'(MAX_DIM) + AW'(q_in.item.coord_index));
    assign item_slot = AW'(AW'(item_reg.cluster_id) * AW'(MAX_DIM) + AW'(item_reg.coord_index));
    assign out_free  = !out_valid_reg || m_ready;

    // saturating sum and divider trial subtract
    always_comb begin
        sum_wide = {ram_rd_data[SUM_W-1], ram_rd_data}
                 + {{(SUM_W-31){item_reg.sample_value[31]}}, item_reg.sample_value};
        shifted  = {rem_reg, quo_reg[SUM_W-1]};
        trial    = shifted - {1'b0, cnt_reg};
        if (neg_reg) begin
            mean_sat = (quo_reg > 56'h80000000) ? 32'h80000000 : 32'(-quo_reg);
        end else begin
            mean_sat = (quo_reg > 56'h7FFFFFFF) ? 32'h7FFFFFFF : quo_reg[31:0];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_addr_reg == LAST_ADDR) state_next = ST_IDLE;
            ST_IDLE: begin
                if (q_in.valid) begin
                    priority case (q_in.item.cmd)
                        CMD_CLEAR: state_next = ST_CLEAR;
                        CMD_ACC:   state_next = ST_ACC;
                        default:   state_next = ST_DLOAD;
                    endcase
                end
            end
            ST_ACC:   state_next = ST_IDLE;
            ST_DLOAD: state_next = (cnt_reg == '0) ? ST_OUT : ST_DIV;
            ST_DIV:   if (bit_reg == 6'(SUM_W - 1)) state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        clr_addr_next = clr_addr_reg;
        item_next     = item_reg;
        cnt_next      = cnt_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        neg_next      = neg_reg;
        bit_next      = bit_reg;
        ovf_next      = ovf_reg;
        counts_next   = counts_reg;
        q_pop         = 1'b0;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = clr_addr_reg;
        ram_wr_data   = '0;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = q_slot;
        out_load      = 1'b0;
        out_data_next = out_data_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_wr_en     = 1'b1;
                clr_addr_next = AW'(clr_addr_reg + 1'b1);
            end
            ST_IDLE: begin
                if (q_in.valid) begin
                    q_pop     = 1'b1;
                    item_next = q_in.item;
                    cnt_next  = counts_reg[q_cid];
                    if (q_in.item.cmd == CMD_CLEAR) begin
                        clr_addr_next = '0;
                        ovf_next      = 1'b0;
                        for (int i = 0; i < MAX_CLUSTERS; i++) counts_next[i] = '0;
                    end else begin
                        ram_rd_en = 1'b1;
                    end
                end
            end
            ST_ACC: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = item_slot;
                if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
                    ram_wr_data = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
                end else begin
                    ram_wr_data = sum_wide[SUM_W-1:0];
                end
                if (item_reg.vector_end) begin
                    if (counts_reg[item_cid] == COUNT_MAX) begin
                        ovf_next = 1'b1;
                    end else begin
                        counts_next[item_cid] = counts_reg[item_cid] + 1'b1;
                    end
                end
            end
            ST_DLOAD: begin
                rem_next = '0;
                bit_next = '0;
                if (cnt_reg == '0) begin
                    neg_next = 1'b0;
                    quo_next = '0;
                end else begin
                    neg_next = ram_rd_data[SUM_W-1];
                    quo_next = ram_rd_data[SUM_W-1] ? SUM_W'(-ram_rd_data) : ram_rd_data;
                end
            end
            ST_DIV: begin
                bit_next = bit_reg + 1'b1;
                if (!trial[COUNT_W]) begin
                    rem_next = trial[COUNT_W-1:0];
                    quo_next = {quo_reg[SUM_W-2:0], 1'b1};
                end else begin
                    rem_next = shifted[COUNT_W-1:0];
                    quo_next = {quo_reg[SUM_W-2:0], 1'b0};
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    out_load                     = 1'b1;
                    out_data_next.mean_value     = mean_sat;
                    out_data_next.cluster_empty  = (cnt_reg == '0);
                    out_data_next.vector_count   = cnt_reg;
                    out_data_next.count_overflow = ovf_reg;
                end
            end
            default: q_pop = 1'b0;
        endcase
        out_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            bit_reg       <= '0;
            for (int i = 0; i < MAX_CLUSTERS; i++) counts_reg[i] <= '0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            bit_reg       <= bit_next;
            counts_reg    <= counts_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        cnt_reg      <= cnt_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        neg_reg      <= neg_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> state_reg == ST_IDLE) else $error("queue popped while busy");
    a_wr_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |-> (state_reg == ST_ACC || state_reg == ST_CLEAR))
        else $error("sum store written outside accumulate or clear");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> $stable(out_data_reg))
        else $error("result overwritten before taken");
`endif
endmodule

### rtl/kmeans_centroid_accumulator.sv
// Top level of the k-means centroid accumulator.
// Accumulate: each word reads the sum store, then adds and writes back.
// Read mean: sum store read, divider load, 56 divider steps, result load; an empty cluster skips the divider steps.
// A two word queue parts the front from the back; config writes always ready.
// Reset and every clear word start a pass over all MAX_CLUSTERS*MAX_DIM sum store
// entries, zeroing them; counts and overflow flag clear at once.
module kmeans_centroid_accumulator #(
    parameter int MAX_CLUSTERS = 16,
    parameter int MAX_DIM      = 128
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  kca_pkg::kca_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output kca_pkg::kca_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_data
);
    import kca_pkg::*;

    kca_q_t q_link;
    logic   q_pop;

    // classify and queue
    kca_front #(.MAX_CLUSTERS(MAX_CLUSTERS), .MAX_DIM(MAX_DIM)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_out     (q_link),
        .q_pop     (q_pop)
    );

    // execute
    kca_back #(.MAX_CLUSTERS(MAX_CLUSTERS), .MAX_DIM(MAX_DIM)) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_in    (q_link),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );
endmodule

### verif/tb_kmeans_centroid_accumulator.sv
// self-checking testbench of the k-means centroid accumulator
`timescale 1ns / 1ps

module tb_kmeans_centroid_accumulator;
    import kca_pkg::*;

    localparam int NCL = 16;
    localparam int NDIM = 128;
    localparam int CLEAR_CYCLES = NCL * NDIM;
    localparam int LONG_HOLD = 300;
    localparam longint CYCLE_LIMIT = 2_000_000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    kca_in_t s_data;
    logic m_valid;
    logic m_ready;
    kca_out_t m_data;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_index;
    logic [7:0] cfg_data;

    kmeans_centroid_accumulator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic signed [SUM_W-1:0] sum_store [NCL*NDIM];
    logic [COUNT_W-1:0] count_store [NCL];
    logic overflow_seen;
    logic [7:0] dim_reg;
    logic [4:0] clusters_reg;

    kca_out_t mean_queue [$];
    int error_count;
    longint cycle_count;
    bit idle_enable;
    int hold_off;
    int long_hold_req;
    int long_hold_seen;

    // clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // cycle limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_kmeans_centroid_accumulator NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    function automatic void wipe_predictor();
        foreach (sum_store[i]) sum_store[i] = '0;
        foreach (count_store[i]) count_store[i] = '0;
        overflow_seen = 1'b0;
    endfunction

    // expected effect of one accepted word
    function automatic void predict_word(input kca_in_t w);
        int slot;
        logic signed [SUM_W:0] total;
        logic signed [SUM_W:0] lim_hi;
        logic signed [SUM_W:0] lim_lo;
        logic [SUM_W-1:0] mag;
        logic [SUM_W-1:0] quot;
        logic neg;
        kca_out_t r;
        lim_hi = SUM_MAX;
        lim_lo = SUM_MIN;
        if (w.cmd == CMD_CLEAR) begin
            wipe_predictor();
            return;
        end
        if (w.cmd != CMD_ACC && w.cmd != CMD_READ) return;
        if (w.cluster_id >= clusters_reg || w.coord_index >= dim_reg) return;
        slot = w.cluster_id * NDIM + w.coord_index;
        if (w.cmd == CMD_ACC) begin
            total = sum_store[slot] + w.sample_value;
            if (total > lim_hi) total = lim_hi;
            if (total < lim_lo) total = lim_lo;
            sum_store[slot] = total[SUM_W-1:0];
            if (w.vector_end) begin
                if (count_store[w.cluster_id] == COUNT_MAX) overflow_seen = 1'b1;
                else count_store[w.cluster_id]++;
            end
            return;
        end
        r = '0;
        r.vector_count = count_store[w.cluster_id];
        r.cluster_empty = (r.vector_count == 0);
        r.count_overflow = overflow_seen;
        if (!r.cluster_empty) begin
            neg = sum_store[slot][SUM_W-1];
            mag = neg ? -sum_store[slot] : sum_store[slot];
            quot = mag / r.vector_count;
            if (neg) begin
                if (quot > 56'h80000000) quot = 56'h80000000;
                r.mean_value = -quot[31:0];
            end else begin
                if (quot > 56'h7FFFFFFF) quot = 56'h7FFFFFFF;
                r.mean_value = quot[31:0];
            end
        end
        mean_queue.insert(mean_queue.size(), r);
    endfunction

    // result side: random stalls, long hold-off on request, checking
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_off <= 0;
            long_hold_seen <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (mean_queue.size() == 0) begin
                    report_mismatch("unexpected word", m_data.mean_value, 0);
                end else begin
                    kca_out_t e;
                    e = mean_queue.pop_front();
                    if (m_data.mean_value !== e.mean_value)
                        report_mismatch("mean_value", m_data.mean_value, e.mean_value);
                    if (m_data.cluster_empty !== e.cluster_empty)
                        report_mismatch("cluster_empty", m_data.cluster_empty, e.cluster_empty);
                    if (m_data.vector_count !== e.vector_count)
                        report_mismatch("vector_count", m_data.vector_count, e.vector_count);
                    if (m_data.count_overflow !== e.count_overflow)
                        report_mismatch("count_overflow", m_data.count_overflow,
                                        e.count_overflow);
                end
            end
            if (long_hold_seen != long_hold_req) begin
                long_hold_seen <= long_hold_req;
                hold_off <= LONG_HOLD - 1;
                m_ready <= 1'b0;
            end else if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_ready <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 7) == 0) begin
                hold_off <= $urandom_range(0, 10);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // send one word, with an optional random gap first; valid stays up until a gap or drain
    task automatic send_word(input kca_in_t w);
        int gap;
        if (idle_enable && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 11);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_word(w);
    endtask

    // wait for every result and for any clear pass to finish
    task automatic drain();
        s_valid <= 1'b0;
        while (mean_queue.size() != 0) @(posedge aclk);
        repeat (CLEAR_CYCLES + 80) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == REG_DIM) dim_reg = (val > NDIM) ? 8'(NDIM) : val;
        else clusters_reg = (val[4:0] > NCL) ? 5'(NCL) : val[4:0];
    endtask

    function automatic kca_in_t make_word(input logic [1:0] c, input int cl, input int co,
                                          input logic [31:0] v, input logic e);
        kca_in_t w;
        w.cmd = c;
        w.cluster_id = 4'(cl);
        w.coord_index = 7'(co);
        w.sample_value = v;
        w.vector_end = e;
        return w;
    endfunction

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 4))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 65535) << 8;
            default: return $urandom;
        endcase
    endfunction

    // extremes, every command, empty and saturating reads, ignored words
    task automatic test_directed();
        send_word(make_word(CMD_READ, 0, 0, 0, 0));
        send_word(make_word(CMD_ACC, 15, 127, 32'h7FFFFFFF, 1));
        send_word(make_word(CMD_ACC, 15, 127, 32'h7FFFFFFF, 0));
        send_word(make_word(CMD_READ, 15, 127, 0, 0));
        send_word(make_word(CMD_ACC, 0, 0, 32'h80000000, 0));
        send_word(make_word(CMD_ACC, 0, 0, 32'h80000000, 1));
        send_word(make_word(CMD_READ, 0, 0, 0, 0));
        send_word(make_word(CMD_ACC, 3, 5, -32'sd7, 1));
        send_word(make_word(CMD_ACC, 3, 5, 0, 1));
        send_word(make_word(CMD_READ, 3, 5, 0, 1));
        send_word(make_word(2'd3, 3, 5, 32'hFFFFFFFF, 1));
        send_word(make_word(CMD_READ, 3, 6, 0, 0));
        send_word(make_word(CMD_CLEAR, 0, 0, 0, 0));
        send_word(make_word(CMD_READ, 3, 5, 0, 0));
        send_word(make_word(CMD_READ, 15, 127, 0, 0));
    endtask

    // narrow config: out-of-range words ignored
    task automatic test_narrow_config();
        write_reg(REG_DIM, 8'd1);
        write_reg(REG_CLUSTERS, 8'd1);
        send_word(make_word(CMD_ACC, 0, 0, 32'h00010000, 1));
        send_word(make_word(CMD_ACC, 1, 0, 32'h00010000, 1));
        send_word(make_word(CMD_ACC, 0, 1, 32'h00010000, 1));
        send_word(make_word(CMD_READ, 0, 0, 0, 0));
        send_word(make_word(CMD_READ, 1, 0, 0, 0));
        write_reg(REG_DIM, 8'd0);
        write_reg(REG_CLUSTERS, 8'd0);
        send_word(make_word(CMD_ACC, 0, 0, 32'h00010000, 1));
        send_word(make_word(CMD_READ, 0, 0, 0, 0));
        write_reg(REG_DIM, 8'd255);
        write_reg(REG_CLUSTERS, 8'd31);
        send_word(make_word(CMD_READ, 0, 0, 0, 0));
    endtask

    // random vectors with a given configuration
    task automatic test_random_vectors(input int n, input int dim, input int ncl);
        int sent;
        int d;
        int cl;
        int k;
        sent = 0;
        write_reg(REG_DIM, 8'(dim));
        write_reg(REG_CLUSTERS, 8'(ncl));
        while (sent < n) begin
            k = $urandom_range(0, 19);
            if (k < 12) begin
                cl = $urandom_range(0, ncl - 1);
                d = (dim > NDIM) ? NDIM : dim;
                for (int i = 0; i < d && i < 6; i++) begin
                    send_word(make_word(CMD_ACC, cl, i, rand_sample(), i == d - 1 || i == 5));
                    sent++;
                end
            end else if (k < 18) begin
                send_word(make_word(CMD_READ, $urandom_range(0, ncl - 1),
                                    $urandom_range(0, 7), $urandom, 1'($urandom)));
                sent++;
            end else if (k == 18) begin
                send_word(make_word(2'($urandom), $urandom, $urandom, $urandom,
                                    1'($urandom)));
                sent++;
            end else begin
                if ($urandom_range(0, 5) == 0)
                    send_word(make_word(CMD_CLEAR, $urandom, $urandom, $urandom,
                                        1'($urandom)));
                else
                    send_word(make_word(CMD_READ, $urandom, $urandom, 0, 0));
                sent++;
            end
        end
    endtask

    // receiver holds off long while the sender keeps offering, then a full pause
    task automatic test_backpressure();
        long_hold_req++;
        for (int i = 0; i < 12; i++)
            send_word(make_word(CMD_READ, $urandom_range(0, 15), $urandom_range(0, 7), 0, 0));
        drain();
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_DIM;
        cfg_data = '0;
        error_count = 0;
        cycle_count = 0;
        idle_enable = 1'b1;
        long_hold_req = 0;
        dim_reg = 8'(NDIM);
        clusters_reg = 5'(NCL);
        wipe_predictor();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_narrow_config();
        test_random_vectors(350, 128, 16);
        test_backpressure();
        test_random_vectors(250, 3, 4);
        test_random_vectors(200, 2, 1);
        idle_enable = 1'b0;
        test_random_vectors(300, 6, 16);
        drain();
        repeat (CLEAR_CYCLES + 100) @(posedge aclk);
        if (error_count == 0 && mean_queue.size() == 0) begin
            $display("tb_kmeans_centroid_accumulator OK");
        end else begin
            $display("tb_kmeans_centroid_accumulator NOT OK");
        end
        $finish;
    end

endmodule

### files.f
rtl/kca_pkg.sv
rtl/kca_ram.sv
rtl/kca_front.sv
rtl/kca_back.sv
rtl/kmeans_centroid_accumulator.sv
verif/tb_kmeans_centroid_accumulator.sv
